// File: sv/dpb_pkg.sv
// Shared types and constants for the dark pixel brightness boost block.
`default_nettype none

package dpb_pkg;

   // Field widths of the pixel, the target register and the brightness arithmetic.
   localparam int CHAN_W   = 8;
   localparam int NUM_CH   = 3;
   localparam int TARGET_W = 18;
   localparam int SUM_W    = 10;
   localparam int D_W      = 20;
   localparam int NUM_W    = 38;

   // One quotient bit per divider cell: the top bit flags saturation.
   localparam int QUO_W    = CHAN_W + 1;

   // Brightness arithmetic constants.
   localparam logic [D_W-1:0]    SUM_SCALE  = 20'd1000;
   localparam logic [D_W-1:0]    EPS_TERM   = 20'd765;
   localparam logic [19:0]       BRIGHT_DEN = 20'd765000;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

   // Channel order in the per-channel arrays.
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Input beat.
   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } dpb_req_type;

   // Result beat.
   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              boosted;
   } dpb_rsp_type;

   // What travels down the divider chain next to the remainders.
   typedef struct packed {
      logic                          boosted;
      dpb_req_type                   pix;
      logic [NUM_CH-1:0][QUO_W-1:0]  quo;
   } dpb_lane_type;

endpackage

`default_nettype wire

// File: sv/dpb_front.sv
// Front stages: brightness term, boost decision and per-channel dividends.
`default_nettype none

module dpb_front #(
   parameter int GAIN_FRAC_BITS = 16,
   parameter int DEN_W          = 36,
   parameter int WORK_W         = 52
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   csr_we,
   input  wire logic [dpb_pkg::TARGET_W-1:0]           csr_wdata,
   input  wire logic                                   req_valid,
   input  wire dpb_pkg::dpb_req_type                   req_data,
   output logic                                        valid_dn,
   output dpb_pkg::dpb_lane_type                       lane_dn,
   output logic [DEN_W-1:0]                            den_dn,
   output logic [dpb_pkg::NUM_CH-1:0][WORK_W-1:0]      rem_dn
);

   localparam int CMP_W  = (DEN_W > dpb_pkg::NUM_W) ? DEN_W : dpb_pkg::NUM_W;
   localparam int PROD_W = dpb_pkg::NUM_W + dpb_pkg::CHAN_W;

   logic [dpb_pkg::NUM_W-1:0]   num_ff, num_in;
   logic                        a_valid_ff;
   dpb_pkg::dpb_req_type        a_pix_ff;
   logic [dpb_pkg::D_W-1:0]     a_d_ff, a_d_in;
   logic [dpb_pkg::SUM_W-1:0]   a_sum;
   logic                        b_valid_ff;
   dpb_pkg::dpb_lane_type       b_lane_ff, b_lane_in;
   logic [DEN_W-1:0]            b_den_ff, b_den_in;
   logic [dpb_pkg::NUM_CH-1:0][WORK_W-1:0] b_rem_ff, b_rem_in;

   // The target is kept pre-scaled by the brightness denominator.
   assign num_in = dpb_pkg::NUM_W'(csr_wdata) * dpb_pkg::NUM_W'(dpb_pkg::BRIGHT_DEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
      end else if (csr_we) begin
         num_ff <= num_in;
      end
   end

   // Stage A: channel sum and the scaled brightness term.
   always_comb begin
      a_sum  = dpb_pkg::SUM_W'(req_data.red_in) + dpb_pkg::SUM_W'(req_data.green_in)
             + dpb_pkg::SUM_W'(req_data.blue_in);
      a_d_in = dpb_pkg::D_W'(a_sum) * dpb_pkg::SUM_SCALE + dpb_pkg::EPS_TERM;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_pix_ff <= req_data;
         a_d_ff   <= a_d_in;
      end
   end

   // Stage B: divisor, boost compare and the three dividends.
   always_comb begin
      b_den_in          = DEN_W'(a_d_ff) << GAIN_FRAC_BITS;
      b_lane_in.boosted = CMP_W'(b_den_in) < CMP_W'(num_ff);
      b_lane_in.pix     = a_pix_ff;
      b_lane_in.quo     = '0;
      b_rem_in[dpb_pkg::CH_RED]   =
         WORK_W'(PROD_W'(num_ff) * PROD_W'(a_pix_ff.red_in));
      b_rem_in[dpb_pkg::CH_GREEN] =
         WORK_W'(PROD_W'(num_ff) * PROD_W'(a_pix_ff.green_in));
      b_rem_in[dpb_pkg::CH_BLUE]  =
         WORK_W'(PROD_W'(num_ff) * PROD_W'(a_pix_ff.blue_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_lane_ff <= b_lane_in;
         b_den_ff  <= b_den_in;
         b_rem_ff  <= b_rem_in;
      end
   end

   assign valid_dn = b_valid_ff;
   assign lane_dn  = b_lane_ff;
   assign den_dn   = b_den_ff;
   assign rem_dn   = b_rem_ff;

endmodule

`default_nettype wire

// File: sv/dpb_div_cell.sv
// One restoring-division cell: resolves one quotient bit for all three channels.
`default_nettype none

module dpb_div_cell #(
   parameter int WORK_W  = 52,
   parameter int DEN_W   = 36,
   parameter int BIT_POS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   en,
   input  wire logic                                   valid_up,
   input  wire dpb_pkg::dpb_lane_type                  lane_up,
   input  wire logic [DEN_W-1:0]                       den_up,
   input  wire logic [dpb_pkg::NUM_CH-1:0][WORK_W-1:0] rem_up,
   output logic                                        valid_dn,
   output dpb_pkg::dpb_lane_type                       lane_dn,
   output logic [DEN_W-1:0]                            den_dn,
   output logic [dpb_pkg::NUM_CH-1:0][WORK_W-1:0]      rem_dn
);

   logic                                    valid_ff;
   dpb_pkg::dpb_lane_type                   lane_ff, lane_in;
   logic [DEN_W-1:0]                        den_ff;
   logic [dpb_pkg::NUM_CH-1:0][WORK_W-1:0]  rem_ff, rem_in;
   logic [WORK_W-1:0]                       den_sh;
   logic [dpb_pkg::NUM_CH-1:0][WORK_W:0]    trial;

   // Subtract the shifted divisor where it fits and record the quotient bit.
   always_comb begin
      den_sh  = WORK_W'(den_up) << BIT_POS;
      lane_in = lane_up;
      rem_in  = rem_up;
      for (int ch = 0; ch < dpb_pkg::NUM_CH; ch++) begin
         trial[ch] = {1'b0, rem_up[ch]} - {1'b0, den_sh};
         if (!trial[ch][WORK_W]) begin
            rem_in[ch]               = trial[ch][WORK_W-1:0];
            lane_in.quo[ch][BIT_POS] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_up;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         den_ff  <= den_up;
         rem_ff  <= rem_in;
      end
   end

   assign valid_dn = valid_ff;
   assign lane_dn  = lane_ff;
   assign den_dn   = den_ff;
   assign rem_dn   = rem_ff;

endmodule

`default_nettype wire

// File: sv/dark_pixel_brightness_boost_core.sv
// Top level of the dark pixel brightness boost: front stages, divider chain, output register.
// Pipeline: twelve register stages (two front stages, nine divider cells of one quotient bit
// each, one output register).
// Throughput: one pixel per cycle; the whole pipeline holds only while a result is stalled.
// Reset clears all valid bits and the target register; payload registers are not reset.
`default_nettype none

module dark_pixel_brightness_boost_core #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [dpb_pkg::TARGET_W-1:0] csr_wdata,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire dpb_pkg::dpb_req_type         req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output dpb_pkg::dpb_rsp_type              rsp_data
);

   localparam int DEN_W     = dpb_pkg::D_W + GAIN_FRAC_BITS;
   localparam int PROD_W    = dpb_pkg::NUM_W + dpb_pkg::CHAN_W;
   localparam int SHIFT_W   = DEN_W + dpb_pkg::CHAN_W;
   localparam int WORK_W    = (PROD_W > SHIFT_W) ? PROD_W : SHIFT_W;
   localparam int CELL_CNT  = dpb_pkg::QUO_W;

   logic                                    en;
   logic                                    valid_chain [0:CELL_CNT];
   dpb_pkg::dpb_lane_type                   lane_chain  [0:CELL_CNT];
   logic [DEN_W-1:0]                        den_chain   [0:CELL_CNT];
   logic [dpb_pkg::NUM_CH-1:0][WORK_W-1:0]  rem_chain   [0:CELL_CNT];
   dpb_pkg::dpb_lane_type                   last_lane;
   logic                                    rsp_valid_ff;
   dpb_pkg::dpb_rsp_type                    rsp_data_ff, rsp_data_in;

   // The pipeline moves unless a finished beat is held at the output.
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   dpb_front #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .DEN_W          (DEN_W),
      .WORK_W         (WORK_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .valid_dn  (valid_chain[0]),
      .lane_dn   (lane_chain[0]),
      .den_dn    (den_chain[0]),
      .rem_dn    (rem_chain[0])
   );

   // Divider chain: the first cell tests for a quotient of 256 or more.
   for (genvar i = 0; i < CELL_CNT; i++) begin : g_cell
      dpb_div_cell #(
         .WORK_W  (WORK_W),
         .DEN_W   (DEN_W),
         .BIT_POS (CELL_CNT - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_up (valid_chain[i]),
         .lane_up  (lane_chain[i]),
         .den_up   (den_chain[i]),
         .rem_up   (rem_chain[i]),
         .valid_dn (valid_chain[i+1]),
         .lane_dn  (lane_chain[i+1]),
         .den_dn   (den_chain[i+1]),
         .rem_dn   (rem_chain[i+1])
      );
   end

   // Pick the boosted or saturated channel, or pass the pixel through.
   function automatic logic [dpb_pkg::CHAN_W-1:0] pick_chan(
      input logic                        boost,
      input logic [dpb_pkg::QUO_W-1:0]   quo,
      input logic [dpb_pkg::CHAN_W-1:0]  chan
   );
      logic [dpb_pkg::CHAN_W-1:0] res;
      if (!boost) begin
         res = chan;
      end else if (quo[dpb_pkg::QUO_W-1]) begin
         res = dpb_pkg::CHAN_MAX;
      end else begin
         res = quo[dpb_pkg::CHAN_W-1:0];
      end
      return res;
   endfunction

   always_comb begin
      last_lane             = lane_chain[CELL_CNT];
      rsp_data_in.boosted   = last_lane.boosted;
      rsp_data_in.red_out   = pick_chan(last_lane.boosted, last_lane.quo[dpb_pkg::CH_RED],
                                        last_lane.pix.red_in);
      rsp_data_in.green_out = pick_chan(last_lane.boosted, last_lane.quo[dpb_pkg::CH_GREEN],
                                        last_lane.pix.green_in);
      rsp_data_in.blue_out  = pick_chan(last_lane.boosted, last_lane.quo[dpb_pkg::CH_BLUE],
                                        last_lane.pix.blue_in);
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= valid_chain[CELL_CNT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
